// ===== rtl/core/spq_pkg.sv =====
// spq_pkg: shared types, constants and codes for the stable priority queue
// used by spq_ctrl and stable_priority_queue; no dependencies
package spq_pkg;

  localparam int QueueDepth = 16;
  localparam int DataBits   = 32;
  localparam int AddrW      = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);
  localparam int CfgW       = 5;
  localparam int TaskW      = 8;
  localparam int PrioW      = 8;
  localparam int InDataW    = TaskW + PrioW + DataBits;
  localparam int OutRawW    = TaskW + PrioW + DataBits + CntW;
  localparam int OutDataW   = ((OutRawW + 7) / 8) * 8;

  // operation selector
  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [TaskW-1:0]    task_id;
    logic [PrioW-1:0]    prio;
    logic [DataBits-1:0] data;
  } entry_t;

  typedef struct packed {
    status_t         status;
    entry_t          entry;
    logic [CntW-1:0] left;
  } result_t;

endpackage

// ===== rtl/core/spq_ram.sv =====
// spq_ram: simple dual-port synchronous ram, one write and one read port
// read data registered; no dependencies
module spq_ram #(
  parameter int Width = 48,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/spq_ctrl.sv =====
// spq_ctrl: sequencer for insert, max-priority scan and shift-down removal
// depends on spq_pkg and spq_ram
module spq_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_func,
  input  spq_pkg::entry_t          in_entry,
  input  logic [spq_pkg::CntW-1:0] limit,
  output logic                     res_valid,
  input  logic                     res_take,
  output spq_pkg::result_t         res
);

  spq_pkg::state_t state, state_next;

  logic [spq_pkg::CntW-1:0]  count;
  logic [spq_pkg::AddrW-1:0] idx;
  logic [spq_pkg::AddrW-1:0] best_idx;
  spq_pkg::entry_t           best_entry;

  logic                      wr_en, rd_en;
  logic [spq_pkg::AddrW-1:0] wr_addr, rd_addr;
  spq_pkg::entry_t           wr_data, rd_entry;

  logic                      accept, can_insert, take_best, scan_last, shift_go, shift_more;
  logic [spq_pkg::AddrW-1:0] best_idx_sel;
  spq_pkg::entry_t           best_sel;
  logic [spq_pkg::CntW-1:0]  cnt_dec, idx_inc;

  spq_ram #(
    .Width($bits(spq_pkg::entry_t)),
    .Depth(spq_pkg::QueueDepth)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_entry)
  );

  assign accept       = in_valid && (state == spq_pkg::S_IDLE);
  assign can_insert   = count < limit;
  assign take_best    = (idx == '0) || (rd_entry.prio > best_entry.prio);
  assign best_idx_sel = take_best ? idx : best_idx;
  assign best_sel     = take_best ? rd_entry : best_entry;
  assign idx_inc      = spq_pkg::CntW'(idx) + spq_pkg::CntW'(1);
  assign scan_last    = idx_inc == count;
  assign cnt_dec      = count - spq_pkg::CntW'(1);
  assign shift_go     = spq_pkg::CntW'(best_idx_sel) < cnt_dec;
  assign shift_more   = idx_inc < count;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      spq_pkg::S_IDLE: begin
        if (accept) begin
          if (in_func == spq_pkg::FUNC_EXTRACT && count != '0) begin
            state_next = spq_pkg::S_SCAN;
          end else begin
            state_next = spq_pkg::S_DONE;
          end
        end
      end
      spq_pkg::S_SCAN: begin
        if (scan_last) begin
          state_next = shift_go ? spq_pkg::S_SHIFT : spq_pkg::S_DONE;
        end
      end
      spq_pkg::S_SHIFT: begin
        if (!shift_more) begin
          state_next = spq_pkg::S_DONE;
        end
      end
      spq_pkg::S_DONE: begin
        if (res_take) begin
          state_next = spq_pkg::S_IDLE;
        end
      end
      default: state_next = spq_pkg::S_IDLE;
    endcase
  end

  // ram controls and handshake outputs
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = in_entry;
    rd_en     = 1'b0;
    rd_addr   = '0;
    case (state)
      spq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (accept && in_func == spq_pkg::FUNC_INSERT && can_insert) begin
          wr_en   = 1'b1;
          wr_addr = count[spq_pkg::AddrW-1:0];
        end
        if (accept && in_func == spq_pkg::FUNC_EXTRACT && count != '0) begin
          rd_en = 1'b1;
        end
      end
      spq_pkg::S_SCAN: begin
        if (!scan_last) begin
          rd_en   = 1'b1;
          rd_addr = idx + spq_pkg::AddrW'(1);
        end else if (shift_go) begin
          rd_en   = 1'b1;
          rd_addr = best_idx_sel + spq_pkg::AddrW'(1);
        end
      end
      spq_pkg::S_SHIFT: begin
        // rd_entry holds slot idx+1, moved down into slot idx
        wr_en   = 1'b1;
        wr_addr = idx;
        wr_data = rd_entry;
        if (shift_more) begin
          rd_en   = 1'b1;
          rd_addr = idx + spq_pkg::AddrW'(2);
        end
      end
      spq_pkg::S_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept && in_func == spq_pkg::FUNC_INSERT && can_insert) begin
        count <= count + spq_pkg::CntW'(1);
      end
      if (state == spq_pkg::S_SCAN && scan_last) begin
        count <= cnt_dec;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      spq_pkg::S_IDLE: begin
        if (accept) begin
          idx <= '0;
          res.entry <= '0;
          if (in_func == spq_pkg::FUNC_INSERT) begin
            res.status <= can_insert ? spq_pkg::STATUS_DONE : spq_pkg::STATUS_FULL;
            res.left   <= can_insert ? count + spq_pkg::CntW'(1) : count;
          end else begin
            res.status <= spq_pkg::STATUS_EMPTY;
            res.left   <= count;
          end
        end
      end
      spq_pkg::S_SCAN: begin
        best_idx   <= best_idx_sel;
        best_entry <= best_sel;
        if (scan_last) begin
          idx        <= best_idx_sel;
          res.status <= spq_pkg::STATUS_DONE;
          res.entry  <= best_sel;
          res.left   <= cnt_dec;
        end else begin
          idx <= idx + spq_pkg::AddrW'(1);
        end
      end
      spq_pkg::S_SHIFT: begin
        idx <= idx + spq_pkg::AddrW'(1);
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

endmodule

// ===== rtl/core/stable_priority_queue.sv =====
// stable_priority_queue: top level with stream ports, size register and result register
// depends on spq_pkg, spq_ctrl (which holds spq_ram)
//
//  channel | direction | signals                              | beat moves when
//  --------+-----------+--------------------------------------+-------------------------
//  s_      | in        | s_tvalid s_tready s_tdata s_tuser    | s_tvalid && s_tready
//  m_      | out       | m_tvalid m_tready m_tdata m_tuser    | m_tvalid && m_tready
//  cfg_    | in        | cfg_valid cfg_ready cfg_data         | cfg_valid && cfg_ready
//
// one operation at a time; entries live in a 16-deep single-write, single-read ram
// insert: one ram write; the result goes through the done state into the output register
// extract: n live entries, k slot of the winner; the scan reads all n slots, one slot per cycle,
//   and the shift-down moves the n - 1 - k slots above k down, one slot per cycle on the ram port
// reset is synchronous; count clears to zero, size in use returns to 16, no ram clearing
// a finished result sits in the output register while the next input beat is taken;
//   the sequencer then holds its own result until the output register frees up
module stable_priority_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // task_id [7:0], priority_req [15:8], event_data [47:16]
  input  logic [spq_pkg::InDataW-1:0]  s_tdata,
  // func [0]
  input  logic                         s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // out_task_id [7:0], out_priority [15:8], out_event_data [47:16],
  // entries_left [52:48], zero pad above
  output logic [spq_pkg::OutDataW-1:0] m_tdata,
  // status [1:0]
  output logic [1:0]                   m_tuser,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [spq_pkg::CfgW-1:0]     cfg_data
);

  logic [spq_pkg::CfgW-1:0] size_in_use;
  logic [spq_pkg::CntW-1:0] limit;
  spq_pkg::entry_t          in_entry;
  spq_pkg::result_t         res;
  logic                     res_valid, res_take;

  // size register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= spq_pkg::CfgW'(spq_pkg::QueueDepth);
    end else if (cfg_valid) begin
      size_in_use <= cfg_data;
    end
  end

  // sizes above the built depth saturate
  assign limit = (size_in_use > spq_pkg::CfgW'(spq_pkg::QueueDepth))
               ? spq_pkg::CntW'(spq_pkg::QueueDepth)
               : spq_pkg::CntW'(size_in_use);

  // unpack the input beat
  assign in_entry.task_id = s_tdata[spq_pkg::TaskW-1:0];
  assign in_entry.prio    = s_tdata[spq_pkg::TaskW +: spq_pkg::PrioW];
  assign in_entry.data    = s_tdata[spq_pkg::TaskW + spq_pkg::PrioW +: spq_pkg::DataBits];

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_func  (s_tuser),
    .in_entry (in_entry),
    .limit    (limit),
    .res_valid(res_valid),
    .res_take (res_take),
    .res      (res)
  );

  // output register loads whenever it is empty or being drained
  assign res_take = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tuser <= res.status;
      m_tdata <= {{(spq_pkg::OutDataW - spq_pkg::OutRawW){1'b0}},
                  res.left, res.entry.data, res.entry.prio, res.entry.task_id};
    end
  end

endmodule
